### rtl/yin_pitch_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// YIN pitch detector assertion macros
// Shared property shorthands for the detector's checks.
// ----------------------------------------------------------------------------
`ifndef YIN_PITCH_DETECTOR_UNIT_DEFINES_SVH
`define YIN_PITCH_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, gated by reset
`define YPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define YPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ypd_pkg.sv
// ----------------------------------------------------------------------------
// YIN pitch detector package
// Widths, limits, register indexes, FSM states and divider request types.
// ----------------------------------------------------------------------------
package ypd_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int STORE_DEPTH = 2 * MAX_WINDOW;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LAG_W       = $clog2(MAX_WINDOW);
  localparam int WLEN_W      = 11;
  localparam int FILL_W      = ADDR_W + 1;
  localparam int W_MIN       = 8;

  localparam int THR_W       = 16;
  localparam int RATE_W      = 18;
  localparam int CFG_W       = 18;
  localparam int CFG_IDX_W   = 2;

  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int ACC_W       = SQ_W + LAG_W;
  localparam int SUM_W       = ACC_W + LAG_W;
  localparam int FRAC_W      = 33;
  localparam int PROD_W      = FRAC_W + LAG_W;
  localparam int CMND_W      = 26;

  localparam int DNUM_W      = 36;
  localparam int DQ_W        = 36;
  localparam int DSTEP_W     = 6;
  localparam logic [DSTEP_W-1:0] FRAC_STEPS = DSTEP_W'(32);
  localparam logic [DSTEP_W-1:0] LONG_STEPS = DSTEP_W'(DNUM_W);

  localparam int PERIOD_W    = 18;
  localparam int FREQ_W      = 26;
  localparam int PRAW_W      = 40;
  localparam logic [CMND_W-1:0]   ONE_Q16    = CMND_W'(65536);
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(256);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(262143);
  localparam logic [FREQ_W-1:0]   FREQ_MAX   = FREQ_W'(50331647);

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(9830);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FRAC,
    ST_MUL,
    ST_WR,
    ST_SRD,
    ST_SCHK,
    ST_WRD,
    ST_WCHK,
    ST_PRD,
    ST_PCHK,
    ST_INTERP,
    ST_FLAUNCH,
    ST_FREQ,
    ST_OUT
  } ypd_state_e;

  typedef struct packed {
    logic               start;
    logic [DSTEP_W-1:0] steps;
    logic [SUM_W-1:0]   rem;
    logic [DNUM_W-1:0]  num;
    logic [SUM_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DQ_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/ypd_if.sv
// ----------------------------------------------------------------------------
// YIN pitch detector channels
// Sample input channel and pitch result channel, valid/ready.
// ----------------------------------------------------------------------------
interface ypd_smp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ypd_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ypd_res_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [ypd_pkg::PERIOD_W-1:0]    period_q8;
  logic [ypd_pkg::FREQ_W-1:0]      freq_q8;

  modport source (output valid, output found, output period_q8, output freq_q8, input ready);
  modport sink   (input valid, input found, input period_q8, input freq_q8, output ready);
endinterface

### rtl/ypd_div.sv
// ----------------------------------------------------------------------------
// YIN pitch detector divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ypd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ypd_pkg::div_req_t req_i,
  output ypd_pkg::div_rsp_t rsp_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [ypd_pkg::DSTEP_W-1:0] cnt_q;
  logic [ypd_pkg::SUM_W-1:0]   rem_q;
  logic [ypd_pkg::DNUM_W-1:0]  num_q;
  logic [ypd_pkg::SUM_W-1:0]   den_q;
  logic [ypd_pkg::DQ_W-1:0]    quot_q;

  logic [ypd_pkg::SUM_W:0]     trial;
  logic                        ge;

  // remainder stays below the divisor, so one extra bit holds the shift
  assign trial = {rem_q, num_q[ypd_pkg::DNUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ypd_pkg::DSTEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? ypd_pkg::SUM_W'(trial - {1'b0, den_q}) : trial[ypd_pkg::SUM_W-1:0];
      num_q  <= {num_q[ypd_pkg::DNUM_W-2:0], 1'b0};
      quot_q <= {quot_q[ypd_pkg::DQ_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### rtl/yin_pitch_detector_unit.sv
// ----------------------------------------------------------------------------
// YIN pitch detector unit
// Buffers 2W samples, runs YIN over one window, emits period and frequency.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                     | handshake
//  smp_i    | in  | sample (s16)                | valid/ready
//  res_o    | out | found, period_q8, freq_q8   | valid/ready
//  cfg      | in  | cfg_we_i, cfg_idx_i, data   | write enable only
//
// A sample that does not complete two windows is stored without starting an analysis.
// The sample that completes them starts an analysis whose length is set
// by the single-MAC difference loop reading two ports of the sample memory,
// plus the shared bit-serial divider.
// smp_i.ready is low during analysis, and while an untaken result holds the next.
// Reset clears control state only; the sample memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "yin_pitch_detector_unit_defines.svh"

module yin_pitch_detector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ypd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ypd_pkg::CFG_W-1:0]     cfg_data_i,
  ypd_smp_if.sink                       smp_i,
  ypd_res_if.source                     res_o
);

  ypd_pkg::ypd_state_e state_q, state_d;

  logic [ypd_pkg::THR_W-1:0]  thr_q;
  logic [ypd_pkg::RATE_W-1:0] rate_q;
  logic [ypd_pkg::WLEN_W-1:0] wlen_q;
  logic [ypd_pkg::WLEN_W-1:0] w_eff;
  logic [ypd_pkg::LAG_W-1:0]  w_m1;
  logic [ypd_pkg::FILL_W-1:0] w2;

  logic [ypd_pkg::FILL_W-1:0] fill_q, fill_inc;
  logic [ypd_pkg::ADDR_W-1:0] start_q;
  logic                       smp_acc;

  logic [ypd_pkg::LAG_W-1:0]  tau_q, i_q;
  logic                       p1_q, p2_q;

  logic [ypd_pkg::SAMPLE_BITS-1:0] smem [ypd_pkg::STORE_DEPTH];
  logic [ypd_pkg::SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic [ypd_pkg::ADDR_W-1:0]      addr_a, addr_b;
  logic signed [ypd_pkg::DIFF_W-1:0]   diff;
  logic signed [2*ypd_pkg::DIFF_W-1:0] sq_full;
  logic [ypd_pkg::SQ_W-1:0]   sq_q;
  logic [ypd_pkg::ACC_W-1:0]  acc_q;
  logic [ypd_pkg::SUM_W-1:0]  sum_q, sum_new;

  logic [ypd_pkg::FRAC_W-1:0] frac_q;
  logic [ypd_pkg::PROD_W-1:0] prod;
  logic [ypd_pkg::CMND_W-1:0] cmnd_q;
  logic [ypd_pkg::CMND_W-1:0] cmem [ypd_pkg::MAX_WINDOW];
  logic [ypd_pkg::CMND_W-1:0] c_rd_q;
  logic [ypd_pkg::LAG_W-1:0]  cmem_raddr;

  logic [ypd_pkg::CMND_W-1:0] cur_q, nxt_q;
  logic                       next_q, found_q, neg_q;

  logic signed [28:0]         t_s;
  logic signed [29:0]         den_s;
  logic signed [26:0]         dn_s;
  logic signed [34:0]         num_s;
  logic [34:0]                num_mag;
  logic [29:0]                den_mag;

  logic signed [ypd_pkg::PRAW_W-1:0] ptau, qsig, praw;
  logic [ypd_pkg::PERIOD_W-1:0] period_q, period_clamp;
  logic [ypd_pkg::FREQ_W-1:0]   freq_sat;
  logic [ypd_pkg::FREQ_W-1:0]   freq_hold_q;

  logic                         out_valid_q, out_found_q;
  logic [ypd_pkg::PERIOD_W-1:0] out_period_q;
  logic [ypd_pkg::FREQ_W-1:0]   out_freq_q;
  logic                         out_load;

  ypd_pkg::div_req_t div_req;
  ypd_pkg::div_rsp_t div_rsp;

  ypd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // effective window, clamped to the supported range
  always_comb begin
    if (wlen_q < ypd_pkg::WLEN_W'(ypd_pkg::W_MIN)) begin
      w_eff = ypd_pkg::WLEN_W'(ypd_pkg::W_MIN);
    end else if (wlen_q > ypd_pkg::WLEN_W'(ypd_pkg::MAX_WINDOW)) begin
      w_eff = ypd_pkg::WLEN_W'(ypd_pkg::MAX_WINDOW);
    end else begin
      w_eff = wlen_q;
    end
  end
  assign w_m1 = ypd_pkg::LAG_W'(w_eff - 1'b1);
  assign w2   = {w_eff, 1'b0};

  assign smp_i.ready = (state_q == ypd_pkg::ST_IDLE);
  assign smp_acc     = smp_i.valid && smp_i.ready;
  assign fill_inc    = fill_q + 1'b1;
  assign out_load    = (state_q == ypd_pkg::ST_OUT) && (!out_valid_q || res_o.ready);

  // difference function datapath
  assign addr_a  = start_q + ypd_pkg::ADDR_W'(i_q);
  assign addr_b  = addr_a + ypd_pkg::ADDR_W'(tau_q);
  assign diff    = $signed({rd_a_q[ypd_pkg::SAMPLE_BITS-1], rd_a_q})
                 - $signed({rd_b_q[ypd_pkg::SAMPLE_BITS-1], rd_b_q});
  assign sq_full = diff * diff;
  assign sum_new = sum_q + ypd_pkg::SUM_W'(acc_q);
  assign prod    = frac_q * ypd_pkg::FRAC_W'(tau_q);

  // parabolic fit: s0 = c_rd_q, s1 = cur_q, s2 = nxt_q
  assign t_s     = $signed({2'b00, cur_q, 1'b0}) - $signed({3'b000, nxt_q})
                 - $signed({3'b000, c_rd_q});
  assign den_s   = {t_s, 1'b0};
  assign dn_s    = $signed({1'b0, nxt_q}) - $signed({1'b0, c_rd_q});
  assign num_s   = {dn_s, 8'b0};
  assign num_mag = num_s[34] ? 35'(-num_s) : 35'(num_s);
  assign den_mag = den_s[29] ? 30'(-den_s) : 30'(den_s);

  assign ptau = $signed(ypd_pkg::PRAW_W'({tau_q, 8'b0}));
  assign qsig = neg_q ? -$signed(ypd_pkg::PRAW_W'(div_rsp.quot))
                      :  $signed(ypd_pkg::PRAW_W'(div_rsp.quot));

  always_comb begin
    if (state_q == ypd_pkg::ST_INTERP) begin
      praw = ptau + qsig;
    end else if (!next_q && (cur_q > c_rd_q)) begin
      praw = ptau - ypd_pkg::PRAW_W'(256);
    end else begin
      praw = ptau;
    end
    if (praw < $signed(ypd_pkg::PRAW_W'(ypd_pkg::PERIOD_MIN))) begin
      period_clamp = ypd_pkg::PERIOD_MIN;
    end else if (praw > $signed(ypd_pkg::PRAW_W'(ypd_pkg::PERIOD_MAX))) begin
      period_clamp = ypd_pkg::PERIOD_MAX;
    end else begin
      period_clamp = praw[ypd_pkg::PERIOD_W-1:0];
    end
  end

  assign freq_sat = (div_rsp.quot > ypd_pkg::DQ_W'(ypd_pkg::FREQ_MAX)) ? ypd_pkg::FREQ_MAX
                  : div_rsp.quot[ypd_pkg::FREQ_W-1:0];

  // sequencer
  always_comb begin
    state_d    = state_q;
    div_req    = '0;
    cmem_raddr = tau_q;
    case (state_q)
      ypd_pkg::ST_IDLE: begin
        if (smp_acc && (fill_inc >= w2)) state_d = ypd_pkg::ST_MAC;
      end
      ypd_pkg::ST_MAC: begin
        if (i_q == w_m1) state_d = ypd_pkg::ST_DRAIN;
      end
      ypd_pkg::ST_DRAIN: begin
        if (!p1_q && !p2_q) begin
          if (sum_new == '0) begin
            state_d = ypd_pkg::ST_WR;
          end else if (ypd_pkg::SUM_W'(acc_q) >= sum_new) begin
            state_d = ypd_pkg::ST_MUL;
          end else begin
            div_req.start = 1'b1;
            div_req.steps = ypd_pkg::FRAC_STEPS;
            div_req.rem   = ypd_pkg::SUM_W'(acc_q);
            div_req.den   = sum_new;
            state_d       = ypd_pkg::ST_FRAC;
          end
        end
      end
      ypd_pkg::ST_FRAC: begin
        if (div_rsp.done) state_d = ypd_pkg::ST_MUL;
      end
      ypd_pkg::ST_MUL: state_d = ypd_pkg::ST_WR;
      ypd_pkg::ST_WR: begin
        state_d = (tau_q == w_m1) ? ypd_pkg::ST_SRD : ypd_pkg::ST_MAC;
      end
      ypd_pkg::ST_SRD: state_d = ypd_pkg::ST_SCHK;
      ypd_pkg::ST_SCHK: begin
        if (c_rd_q < ypd_pkg::CMND_W'(thr_q)) begin
          state_d = ypd_pkg::ST_WRD;
        end else if (tau_q == w_m1) begin
          state_d = ypd_pkg::ST_OUT;
        end else begin
          state_d = ypd_pkg::ST_SRD;
        end
      end
      ypd_pkg::ST_WRD: begin
        cmem_raddr = tau_q + 1'b1;
        state_d    = (tau_q == w_m1) ? ypd_pkg::ST_PRD : ypd_pkg::ST_WCHK;
      end
      ypd_pkg::ST_WCHK: begin
        state_d = (c_rd_q < cur_q) ? ypd_pkg::ST_WRD : ypd_pkg::ST_PRD;
      end
      ypd_pkg::ST_PRD: begin
        cmem_raddr = tau_q - 1'b1;
        state_d    = ypd_pkg::ST_PCHK;
      end
      ypd_pkg::ST_PCHK: begin
        if (next_q && (den_s != '0)) begin
          div_req.start = 1'b1;
          div_req.steps = ypd_pkg::LONG_STEPS;
          div_req.num   = ypd_pkg::DNUM_W'(num_mag);
          div_req.den   = ypd_pkg::SUM_W'(den_mag);
          state_d       = ypd_pkg::ST_INTERP;
        end else begin
          state_d = ypd_pkg::ST_FLAUNCH;
        end
      end
      ypd_pkg::ST_INTERP: begin
        if (div_rsp.done) state_d = ypd_pkg::ST_FLAUNCH;
      end
      ypd_pkg::ST_FLAUNCH: begin
        div_req.start = 1'b1;
        div_req.steps = ypd_pkg::LONG_STEPS;
        div_req.num   = ypd_pkg::DNUM_W'({rate_q, 16'b0});
        div_req.den   = ypd_pkg::SUM_W'(period_q);
        state_d       = ypd_pkg::ST_FREQ;
      end
      ypd_pkg::ST_FREQ: begin
        if (div_rsp.done) state_d = ypd_pkg::ST_OUT;
      end
      ypd_pkg::ST_OUT: begin
        if (out_load) state_d = ypd_pkg::ST_IDLE;
      end
      default: state_d = ypd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ypd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ypd_pkg::THR_RESET;
      rate_q      <= ypd_pkg::RATE_RESET;
      wlen_q      <= ypd_pkg::WLEN_RESET;
      fill_q      <= '0;
      start_q     <= '0;
      tau_q       <= '0;
      i_q         <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_q <= (state_q == ypd_pkg::ST_MAC);
      p2_q <= p1_q;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          ypd_pkg::REG_THRESHOLD: thr_q <= cfg_data_i[ypd_pkg::THR_W-1:0];
          ypd_pkg::REG_RATE:      rate_q <= cfg_data_i[ypd_pkg::RATE_W-1:0];
          ypd_pkg::REG_WINDOW: begin
            wlen_q  <= cfg_data_i[ypd_pkg::WLEN_W-1:0];
            fill_q  <= '0;
            start_q <= '0;
          end
          default: ;
        endcase
      end else if (smp_acc) begin
        fill_q <= fill_inc;
      end else if (out_load) begin
        fill_q  <= fill_q - ypd_pkg::FILL_W'(w_eff);
        start_q <= start_q + ypd_pkg::ADDR_W'(w_eff);
      end

      case (state_q)
        ypd_pkg::ST_IDLE: begin
          tau_q <= ypd_pkg::LAG_W'(1);
          i_q   <= '0;
        end
        ypd_pkg::ST_MAC: i_q <= i_q + 1'b1;
        ypd_pkg::ST_WR: begin
          i_q   <= '0;
          tau_q <= (tau_q == w_m1) ? ypd_pkg::LAG_W'(2) : tau_q + 1'b1;
        end
        ypd_pkg::ST_SCHK: begin
          if ((c_rd_q >= ypd_pkg::CMND_W'(thr_q)) && (tau_q != w_m1)) tau_q <= tau_q + 1'b1;
        end
        ypd_pkg::ST_WCHK: begin
          if (c_rd_q < cur_q) tau_q <= tau_q + 1'b1;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memories: two read ports on samples, one on the normalized difference
  always_ff @(posedge clk_i) begin
    if (smp_acc) smem[start_q + fill_q[ypd_pkg::ADDR_W-1:0]] <= smp_i.sample;
    rd_a_q <= smem[addr_a];
    rd_b_q <= smem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ypd_pkg::ST_WR) cmem[tau_q] <= cmnd_q;
    c_rd_q <= cmem[cmem_raddr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    sq_q <= ypd_pkg::SQ_W'(sq_full);

    if ((state_q == ypd_pkg::ST_IDLE) || (state_q == ypd_pkg::ST_WR)) begin
      acc_q <= '0;
    end else if (p2_q) begin
      acc_q <= acc_q + ypd_pkg::ACC_W'(sq_q);
    end

    if (state_q == ypd_pkg::ST_IDLE) begin
      sum_q   <= '0;
      found_q <= 1'b0;
      next_q  <= 1'b0;
    end

    if ((state_q == ypd_pkg::ST_DRAIN) && !p1_q && !p2_q) begin
      sum_q  <= sum_new;
      cmnd_q <= ypd_pkg::ONE_Q16;
      frac_q <= {1'b1, 32'b0};
    end
    if ((state_q == ypd_pkg::ST_FRAC) && div_rsp.done) begin
      frac_q <= {1'b0, div_rsp.quot[31:0]};
    end
    if (state_q == ypd_pkg::ST_MUL) begin
      cmnd_q <= prod[16 +: ypd_pkg::CMND_W];
    end

    if (state_q == ypd_pkg::ST_SCHK) cur_q <= c_rd_q;
    if (state_q == ypd_pkg::ST_WRD)  next_q <= 1'b0;
    if (state_q == ypd_pkg::ST_WCHK) begin
      if (c_rd_q < cur_q) begin
        cur_q <= c_rd_q;
      end else begin
        nxt_q  <= c_rd_q;
        next_q <= 1'b1;
      end
    end

    if (state_q == ypd_pkg::ST_PCHK) begin
      found_q  <= 1'b1;
      neg_q    <= num_s[34] ^ den_s[29];
      period_q <= period_clamp;
    end
    if ((state_q == ypd_pkg::ST_INTERP) && div_rsp.done) period_q <= period_clamp;

    if ((state_q == ypd_pkg::ST_FREQ) && div_rsp.done) freq_hold_q <= freq_sat;
    if (out_load) begin
      out_found_q  <= found_q;
      out_period_q <= found_q ? period_q : '0;
      out_freq_q   <= found_q ? freq_hold_q : '0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.found     = out_found_q;
  assign res_o.period_q8 = out_period_q;
  assign res_o.freq_q8   = out_freq_q;

  `YPD_ASSERT_IMPL(a_div_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `YPD_ASSERT_IMPL(a_fill_bound, state_q == ypd_pkg::ST_IDLE, fill_q < w2, "two windows held while idle")
  `YPD_ASSERT_IMPL(a_found_period, out_valid_q && out_found_q, out_period_q >= ypd_pkg::PERIOD_MIN, "period under one sample")
  `YPD_ASSERT_NEXT(a_result_load, out_load, out_valid_q && (state_q == ypd_pkg::ST_IDLE), "result not presented")

endmodule
